// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the tracker's RTL files.
// Every user module has i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, muted while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Clocked implication built on the check above.
`define ASSERT_IMP(lbl, ante, cons, msg) \
    `ASSERT_CLK(lbl, (ante) |-> cons, msg)

`endif

// ===== sv/hct_pkg.sv =====
`default_nettype none

package hct_pkg;

    localparam int ENC_W       = 32;
    localparam int HALL_W      = 3;
    localparam int TICKS_W     = 16;
    localparam int COEFF_W     = 16;
    localparam int ROT_W       = 10;
    localparam int ADV_W       = 26;
    localparam int CFG_DATA_W  = 32;

    localparam logic [ADV_W-1:0]  ADV_MAX   = '1;
    localparam int                IDX_MAX   = 1023;
    localparam logic [ENC_W-1:0]  RES_RESET = 32'd4096;

    // Hall patterns whose transition marks the electrical zero.
    localparam logic [HALL_W-1:0] PAT_ZERO_A = 3'b011;
    localparam logic [HALL_W-1:0] PAT_ZERO_B = 3'b001;

    typedef enum logic {
        KIND_HALL  = 1'b0,
        KIND_QUERY = 1'b1
    } t_kind;

    typedef enum logic {
        REG_ENC_RES   = 1'b0,
        REG_ADV_COEFF = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        t_kind                kind;
        logic [ENC_W-1:0]     encoder_count;
        logic [HALL_W-1:0]    hall_bits;
        logic [TICKS_W-1:0]   captured_ticks;
    } t_in;

    typedef struct packed {
        logic [ROT_W-1:0]     rotor_index;
        logic [ADV_W-1:0]     index_advance;
        logic                 synced;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DIV1,
        S_WAIT1,
        S_DIV2,
        S_WAIT2,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        DIV_ADV,
        DIV_MOD,
        DIV_IDX
    } t_div_sel;

    typedef struct packed {
        logic     capture;
        logic     prep;
        logic     div_start;
        t_div_sel div_sel;
        logic     adv_zero;
        logic     adv_store;
        logic     mul;
        logic     idx_store;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  res_zero;
        logic  step_zero;
        logic  div_done;
        logic  div_busy;
    } t_sts;

endpackage

`default_nettype wire

// ===== sv/hct_div.sv =====
`default_nettype none
`include "assert_macros.svh"

module hct_div
    import hct_pkg::*;
#(
    parameter int NUM_W = 43,
    parameter int DEN_W = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_dividend,
    input  wire logic [DEN_W-1:0] i_divisor,
    output logic                  o_busy,
    output logic                  o_done,
    output logic      [NUM_W-1:0] o_quo,
    output logic      [DEN_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_quo, n_quo;
    logic [DEN_W-1:0] r_rem, n_rem;
    logic [DEN_W-1:0] r_den, n_den;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;

    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   trial;

    // Restoring division, one quotient bit per cycle.
    assign rem_sh = {r_rem, r_quo[NUM_W-1]};
    assign trial  = rem_sh - {1'b0, r_den};

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_quo  = i_dividend;
            n_rem  = '0;
            n_den  = i_divisor;
            n_cnt  = CNT_W'(NUM_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!trial[DEN_W]) begin
                n_rem = trial[DEN_W-1:0];
                n_quo = {r_quo[NUM_W-2:0], 1'b1};
            end else begin
                n_rem = rem_sh[DEN_W-1:0];
                n_quo = {r_quo[NUM_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
        r_cnt <= n_cnt;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

    `ASSERT_IMP(a_start_runs, i_start, ##1 r_busy, "divider did not start")
    `ASSERT_IMP(a_done_ends_run, r_done, !r_busy && $past(r_busy), "stray divider done")

endmodule

`default_nettype wire

// ===== sv/hct_dp.sv =====
`default_nettype none
`include "assert_macros.svh"

module hct_dp
    import hct_pkg::*;
#(
    parameter int TABLE_LENGTH = 1024
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_in                   i_in_data,
    input  wire logic                  i_cfg_valid,
    input  wire t_cfg_reg              i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire t_cmd                  i_cmd,
    output t_sts                       o_sts,
    output t_out                       o_out_data
);

    localparam int LW      = $clog2(TABLE_LENGTH + 1);
    localparam int NUM_W   = ENC_W + LW;
    localparam int K_VAL   = (TABLE_LENGTH / 6) * 5;
    localparam int KW      = $clog2(K_VAL + 1);
    localparam int PW      = COEFF_W + KW;
    localparam int IDX_CAP = (TABLE_LENGTH - 1 < IDX_MAX) ? TABLE_LENGTH - 1 : IDX_MAX;

    t_in                 r_item;
    logic [ENC_W-1:0]    r_res;
    logic [COEFF_W-1:0]  r_coeff;
    logic [ENC_W-1:0]    r_zero;
    logic [HALL_W-1:0]   r_last_pat;
    logic [HALL_W-1:0]   r_older_pat;
    logic [TICKS_W-1:0]  r_step;
    logic [ADV_W-1:0]    r_adv;
    logic                r_sync;
    logic [ROT_W-1:0]    r_rotor;
    logic [NUM_W-1:0]    r_num;
    t_out                r_out;

    logic [PW-1:0]       adv_prod;
    logic [NUM_W-1:0]    idx_prod;
    logic [ENC_W-1:0]    enc_rel;
    logic                zero_cross;
    logic [NUM_W-1:0]    div_dividend;
    logic [ENC_W-1:0]    div_divisor;
    logic                div_busy;
    logic                div_done;
    logic [NUM_W-1:0]    div_quo;
    logic [ENC_W-1:0]    div_rem;

    assign adv_prod = PW'(r_coeff) * PW'(K_VAL);
    assign idx_prod = NUM_W'(div_rem) * NUM_W'(TABLE_LENGTH);

    // Encoder offset from the zero position, wrapping at the encoder width.
    assign enc_rel = r_item.encoder_count - r_zero;

    assign zero_cross = (r_last_pat == PAT_ZERO_A && r_item.hall_bits == PAT_ZERO_B) ||
                        (r_last_pat == PAT_ZERO_B && r_item.hall_bits == PAT_ZERO_A);

    always_comb begin
        case (i_cmd.div_sel)
            DIV_ADV: begin
                div_dividend = r_num;
                div_divisor  = ENC_W'(r_step);
            end
            DIV_MOD: begin
                div_dividend = NUM_W'(enc_rel);
                div_divisor  = r_res;
            end
            DIV_IDX: begin
                div_dividend = r_num;
                div_divisor  = r_res;
            end
            default: begin
                div_dividend = r_num;
                div_divisor  = r_res;
            end
        endcase
    end

    hct_div #(
        .NUM_W (NUM_W),
        .DEN_W (ENC_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res   <= RES_RESET;
            r_coeff <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ENC_RES:   r_res   <= i_cfg_data;
                REG_ADV_COEFF: r_coeff <= i_cfg_data[COEFF_W-1:0];
                default:       r_res   <= r_res;
            endcase
        end
    end

    // Tracking state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero      <= '0;
            r_last_pat  <= '0;
            r_older_pat <= '0;
            r_step      <= '0;
            r_adv       <= '0;
            r_sync      <= 1'b0;
            r_rotor     <= '0;
        end else begin
            if (i_cmd.prep) begin
                if (r_item.kind == KIND_HALL) begin
                    if (zero_cross) begin
                        r_zero <= r_item.encoder_count;
                        r_sync <= 1'b1;
                    end
                    if (r_item.hall_bits != r_older_pat) begin
                        r_step <= r_item.captured_ticks;
                    end
                    r_older_pat <= r_last_pat;
                    r_last_pat  <= r_item.hall_bits;
                end else if (r_res == '0) begin
                    r_rotor <= '0;
                end else if (r_item.encoder_count < r_zero) begin
                    r_zero <= r_zero - r_res;
                end
            end
            if (i_cmd.adv_zero) begin
                r_adv <= '0;
            end
            if (i_cmd.adv_store) begin
                r_adv <= (div_quo > NUM_W'(ADV_MAX)) ? ADV_MAX : div_quo[ADV_W-1:0];
            end
            if (i_cmd.idx_store) begin
                r_rotor <= (div_quo > NUM_W'(IDX_CAP)) ? ROT_W'(IDX_CAP)
                                                       : div_quo[ROT_W-1:0];
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_data;
        end
        if (i_cmd.prep) begin
            r_num <= NUM_W'(adv_prod);
        end else if (i_cmd.mul) begin
            r_num <= idx_prod;
        end
        if (i_cmd.out_load) begin
            r_out.rotor_index   <= r_rotor;
            r_out.index_advance <= r_adv;
            r_out.synced        <= r_sync;
        end
    end

    assign o_sts.kind      = r_item.kind;
    assign o_sts.res_zero  = (r_res == '0);
    assign o_sts.step_zero = (r_step == '0);
    assign o_sts.div_done  = div_done;
    assign o_sts.div_busy  = div_busy;
    assign o_out_data      = r_out;

    `ASSERT_IMP(a_sync_sticky, r_sync, ##1 r_sync, "sync flag dropped")
    `ASSERT_IMP(a_idx_in_table, i_cmd.idx_store, div_quo < NUM_W'(TABLE_LENGTH),
        "rotor quotient beyond table")

endmodule

`default_nettype wire

// ===== sv/hct_ctrl.sv =====
`default_nettype none
`include "assert_macros.svh"

module hct_ctrl
    import hct_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_PREP;
            end
            S_PREP: begin
                if (i_sts.kind == KIND_QUERY && i_sts.res_zero) n_state = S_OUT;
                else n_state = S_DIV1;
            end
            S_DIV1: begin
                if (i_sts.kind == KIND_HALL && i_sts.step_zero) n_state = S_OUT;
                else n_state = S_WAIT1;
            end
            S_WAIT1: begin
                if (i_sts.div_done) begin
                    n_state = (i_sts.kind == KIND_HALL) ? S_OUT : S_DIV2;
                end
            end
            S_DIV2: begin
                n_state = S_WAIT2;
            end
            S_WAIT2: begin
                if (i_sts.div_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.div_sel = DIV_ADV;
        case (r_state)
            S_IDLE: begin
                o_cmd.capture = i_in_valid;
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
            end
            S_DIV1: begin
                if (i_sts.kind == KIND_HALL) begin
                    o_cmd.div_sel   = DIV_ADV;
                    o_cmd.adv_zero  = i_sts.step_zero;
                    o_cmd.div_start = !i_sts.step_zero;
                end else begin
                    o_cmd.div_sel   = DIV_MOD;
                    o_cmd.div_start = 1'b1;
                end
            end
            S_WAIT1: begin
                if (i_sts.kind == KIND_HALL) o_cmd.adv_store = i_sts.div_done;
                else o_cmd.mul = i_sts.div_done;
            end
            S_DIV2: begin
                o_cmd.div_sel   = DIV_IDX;
                o_cmd.div_start = 1'b1;
            end
            S_WAIT2: begin
                o_cmd.idx_store = i_sts.div_done;
            end
            S_OUT: begin
                o_cmd.out_load = !r_out_valid || i_out_ready;
            end
            default: begin
                o_cmd.capture = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    `ASSERT_IMP(a_idle_div_quiet, r_state == S_IDLE, !i_sts.div_busy,
        "divider busy while idle")
    `ASSERT_IMP(a_load_has_room, o_cmd.out_load, !r_out_valid || i_out_ready,
        "result overwritten before delivery")

endmodule

`default_nettype wire

// ===== sv/hall_commutation_tracker_unit.sv =====
// Divisions: a hall edge takes one division, none when the step duration is zero; a
// position query takes two, none at zero resolution.
// NUM_W = 32 + clog2(TABLE_LENGTH + 1), 43 at the default table length: the shared
// restoring divider resolves one quotient bit per cycle over NUM_W bits.
// Throughput: one item at a time; the next beat is taken once the result is registered.
// Reset: synchronous, active low; tracking, config and control state return to defaults.
`default_nettype none

module hall_commutation_tracker_unit
    import hct_pkg::*;
#(
    parameter int TABLE_LENGTH = 1024
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Input item channel. kind selects hall edge or position query.
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in                   i_in_data,
    // Result channel. Every input beat yields exactly one result beat.
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out                       o_out_data,
    // Configuration write channel; write it only while idle, the block does not enforce this.
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire t_cfg_reg              i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    // Registers are plain flops, so a write can always be taken.
    assign o_cfg_ready = 1'b1;

    // The controller sequences each item: capture, state update, one division for a
    // hall edge (the index advance) or two for a query (the modulo, then the scaling
    // onto the commutation table; none at zero step or resolution), then the output load.
    hct_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // The datapath holds the configuration, the rotor tracking state, the shared
    // divider and the output register that carries the result beat.
    hct_dp #(
        .TABLE_LENGTH (TABLE_LENGTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
